FILE: hdl/gif89a_container_parser_macros.svh
// assertion helpers for the container parser checker
`ifndef GIF89A_CONTAINER_PARSER_MACROS_SVH
`define GIF89A_CONTAINER_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GCP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define GCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/gcp_pkg.sv
// ---------------------------------------------------------------------------
// gcp_pkg
// Types, codes and constants shared by the container parser modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gcp_pkg;

	localparam int COUNT_BITS = 24;
	localparam int FRAME_BITS = 16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [4:0]  error_code;
		logic [15:0] word_a;
		logic [15:0] word_b;
		logic [15:0] word_c;
		logic [15:0] word_d;
		logic [7:0]  packed_flags;
		logic [7:0]  byte_one;
		logic [7:0]  byte_two;
		logic [15:0] frame_number;
		logic [23:0] byte_count;
		logic        last_of_run;
	} out_word_t;

	localparam logic [2:0] EV_SCREEN = 3'd0;
	localparam logic [2:0] EV_GCE    = 3'd1;
	localparam logic [2:0] EV_LOOP   = 3'd2;
	localparam logic [2:0] EV_FRAME  = 3'd3;
	localparam logic [2:0] EV_DATA   = 3'd4;
	localparam logic [2:0] EV_FINISH = 3'd5;
	localparam logic [2:0] EV_ERROR  = 3'd6;

	localparam logic [4:0] ERR_NONE      = 5'd0;
	localparam logic [4:0] ERR_SIG       = 5'd1;
	localparam logic [4:0] ERR_VER       = 5'd2;
	localparam logic [4:0] ERR_TRUNC     = 5'd3;
	localparam logic [4:0] ERR_GCE_SIZE  = 5'd4;
	localparam logic [4:0] ERR_GCE_TERM  = 5'd5;
	localparam logic [4:0] ERR_DISPOSAL  = 5'd6;
	localparam logic [4:0] ERR_GCE_TWICE = 5'd7;
	localparam logic [4:0] ERR_APP_SIZE  = 5'd8;
	localparam logic [4:0] ERR_APP_ID    = 5'd9;
	localparam logic [4:0] ERR_APP_AUTH  = 5'd10;
	localparam logic [4:0] ERR_LOOP_SIZE = 5'd11;
	localparam logic [4:0] ERR_LOOP_ID   = 5'd12;
	localparam logic [4:0] ERR_LOOP_TERM = 5'd13;
	localparam logic [4:0] ERR_EXT       = 5'd14;
	localparam logic [4:0] ERR_FR_SIZE   = 5'd15;
	localparam logic [4:0] ERR_FR_BOUNDS = 5'd16;
	localparam logic [4:0] ERR_FR_EMPTY  = 5'd17;
	localparam logic [4:0] ERR_NO_FRAME  = 5'd18;
	localparam logic [4:0] ERR_BLOCK     = 5'd19;

	localparam logic [7:0] B_EXT     = 8'h21;
	localparam logic [7:0] B_IMG     = 8'h2C;
	localparam logic [7:0] B_TRAILER = 8'h3B;
	localparam logic [7:0] X_GCE     = 8'hF9;
	localparam logic [7:0] X_APP     = 8'hFF;
	localparam logic [7:0] X_COMMENT = 8'hFE;
	localparam logic [7:0] X_TEXT    = 8'h01;

	function automatic logic [7:0] sig_byte(input logic [3:0] i);
		case (i)
			4'd0: sig_byte = 8'h47;
			4'd1: sig_byte = 8'h49;
			4'd2: sig_byte = 8'h46;
			4'd3: sig_byte = 8'h38;
			4'd4: sig_byte = 8'h39;
			4'd5: sig_byte = 8'h61;
			default: sig_byte = 8'h00;
		endcase
	endfunction

	// application identifier and auth code, indexed from the first id byte
	function automatic logic [7:0] app_byte(input logic [3:0] i);
		case (i)
			4'd0: app_byte = 8'h4E;
			4'd1: app_byte = 8'h45;
			4'd2: app_byte = 8'h54;
			4'd3: app_byte = 8'h53;
			4'd4: app_byte = 8'h43;
			4'd5: app_byte = 8'h41;
			4'd6: app_byte = 8'h50;
			4'd7: app_byte = 8'h45;
			4'd8: app_byte = 8'h32;
			4'd9: app_byte = 8'h2E;
			4'd10: app_byte = 8'h30;
			default: app_byte = 8'h00;
		endcase
	endfunction

	function automatic logic [9:0] table_bytes(input logic [7:0] flags);
		table_bytes = 10'(10'd3 << ({1'b0, flags[2:0]} + 4'd1));
	endfunction

endpackage
`default_nettype wire

FILE: hdl/gif89a_container_parser.sv
// ---------------------------------------------------------------------------
// GIF89a container parser
// in channel: one file byte per word, is_last on the final byte of a file.
// out channel: screen, graphics control, loop, frame, frame data, finish
// and error records; last_of_run marks the final record caused by a byte.
// one byte is accepted per cycle while ready is high; records are registered
// in a four-word queue and leave it one record per cycle while the receiver is ready.
// a byte yields at most two records, so ready drops while fewer than two
// queue slots are free; with the receiver ready the rate is one byte a cycle.
// after an error the parser drops bytes silently up to is_last.
// reset clears all parse state and empties the queue; is_last also returns
// the parser to its reset state after its records are queued.
// a stalled receiver fills the queue and then holds the input side off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gif89a_container_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire gcp_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output gcp_pkg::out_word_t      out_data
);
	import gcp_pkg::*;

	out_word_t  r0, r1;
	logic [1:0] n, push_n;
	logic       step;

	assign step = in_valid && in_ready;
	assign push_n = step ? n : 2'd0;

	gcp_core u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .in_word(in_data),
		.res0(r0), .res1(r1), .res_n(n)
	);

	gcp_outq u_q (
		.clk(clk), .arst_n(arst_n), .push_n(push_n), .push0(r0), .push1(r1),
		.room(in_ready), .valid(out_valid), .ready(out_ready), .head(out_data)
	);
endmodule
`default_nettype wire

FILE: hdl/gcp_core.sv
// ---------------------------------------------------------------------------
// gcp_core
// Parser state and per-byte step logic; yields up to two result words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gcp_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire gcp_pkg::in_word_t  in_word,
	output gcp_pkg::out_word_t      res0,
	output gcp_pkg::out_word_t      res1,
	output logic [1:0]              res_n
);
	import gcp_pkg::*;

	typedef enum logic [3:0] {
		P_SIG, P_SCREEN, P_GCT, P_BLOCK, P_EXT_TYPE, P_GCE, P_APP_HEAD, P_APP_TAIL,
		P_SKIP_LEN, P_SKIP_DATA, P_IMG, P_LCT, P_MIN, P_DLEN, P_DSKIP, P_TAIL
	} phase_t;

	localparam logic [COUNT_BITS-1:0] CCAP = '1;
	localparam logic [FRAME_BITS-1:0] FCAP = '1;

	phase_t                phase_q, phase_d;
	logic [3:0]            off_q, off_d;
	logic [9:0]            skip_q, skip_d;
	logic [COUNT_BITS-1:0] sum_q, sum_d;
	logic [15:0]           cw_q, cw_d, ch_q, ch_d;
	logic [15:0]           gw_q [4];
	logic [15:0]           gw_d [4];
	logic [7:0]            gf0_q, gf0_d, gf1_q, gf1_d;
	logic [FRAME_BITS-1:0] fc_q, fc_d;
	logic                  gce_q, gce_d, halt_q, halt_d;

	logic [7:0]  b;
	logic [4:0]  err;
	logic        rec;
	out_word_t   r, tail;
	logic [16:0] sw, sh;
	logic [COUNT_BITS:0] sum_add;
	logic [15:0] fn16;

	assign b = in_word.data_byte;
	assign fn16 = 16'(fc_q);

	always_comb begin
		phase_d = phase_q; off_d = off_q; skip_d = skip_q; sum_d = sum_q;
		cw_d = cw_q; ch_d = ch_q; gw_d = gw_q; gf0_d = gf0_q; gf1_d = gf1_q;
		fc_d = fc_q; gce_d = gce_q; halt_d = halt_q;
		err = ERR_NONE; rec = 1'b0; r = '0; tail = '0; res_n = 2'd0;
		sw = {1'b0, gw_q[2]} + {1'b0, gw_q[0]};
		sh = {1'b0, gw_q[3]} + {1'b0, gw_q[1]};
		sum_add = {1'b0, sum_q} + {{COUNT_BITS-7{1'b0}}, b};
		if (!halt_q) begin
			unique case (phase_q)
				P_SIG: begin
					if (off_q > 4'd5 || b != sig_byte(off_q))
						err = (off_q < 4'd3) ? ERR_SIG : ERR_VER;
					else if (off_q == 4'd5) begin
						phase_d = P_SCREEN; off_d = '0;
					end else off_d = off_q + 4'd1;
				end
				P_SCREEN: begin
					case (off_q)
						4'd0: cw_d = {8'h00, b};
						4'd1: cw_d = {b, cw_q[7:0]};
						4'd2: ch_d = {8'h00, b};
						4'd3: ch_d = {b, ch_q[7:0]};
						4'd4: gf0_d = b;
						4'd5: gf1_d = b;
						default: begin
							rec = 1'b1;
							r.event_kind = EV_SCREEN; r.word_a = cw_q; r.word_b = ch_q;
							r.packed_flags = gf0_q; r.byte_one = gf1_q; r.byte_two = b;
							if (gf0_q[7]) begin
								skip_d = table_bytes(gf0_q); phase_d = P_GCT;
							end else phase_d = P_BLOCK;
						end
					endcase
					off_d = off_q + 4'd1;
				end
				P_GCT, P_LCT, P_SKIP_DATA, P_DSKIP: begin
					skip_d = (skip_q != '0) ? skip_q - 10'd1 : skip_q;
					if (skip_d == '0) begin
						case (phase_q)
							P_GCT: phase_d = P_BLOCK;
							P_LCT: phase_d = P_MIN;
							P_SKIP_DATA: phase_d = P_SKIP_LEN;
							default: phase_d = P_DLEN;
						endcase
					end
				end
				P_BLOCK: begin
					off_d = '0;
					if (b == B_EXT) phase_d = P_EXT_TYPE;
					else if (b == B_IMG) phase_d = P_IMG;
					else if (b == B_TRAILER) begin
						if (fc_q == '0) err = ERR_NO_FRAME;
						else begin
							phase_d = P_TAIL; sum_d = '0;
						end
					end else err = ERR_BLOCK;
				end
				P_EXT_TYPE: begin
					off_d = '0;
					if (b == X_GCE) begin
						if (gce_q) err = ERR_GCE_TWICE;
						else begin
							gce_d = 1'b1; phase_d = P_GCE;
						end
					end else if (b == X_APP) phase_d = P_APP_HEAD;
					else if (b == X_COMMENT || b == X_TEXT) phase_d = P_SKIP_LEN;
					else err = ERR_EXT;
				end
				P_GCE: begin
					case (off_q)
						4'd0: if (b != 8'd4) err = ERR_GCE_SIZE;
						4'd1: gf0_d = b;
						4'd2: gw_d[0] = {8'h00, b};
						4'd3: gw_d[0] = {b, gw_q[0][7:0]};
						4'd4: gf1_d = b;
						default: begin
							if (b != 8'd0) err = ERR_GCE_TERM;
							else if (gf0_q[4:2] > 3'd3) err = ERR_DISPOSAL;
							else begin
								rec = 1'b1;
								r.event_kind = EV_GCE; r.word_a = gw_q[0];
								r.packed_flags = gf0_q; r.byte_one = gf1_q;
								r.frame_number = fn16; phase_d = P_BLOCK;
							end
						end
					endcase
					off_d = off_q + 4'd1;
				end
				P_APP_HEAD: begin
					if (off_q == 4'd0) begin
						if (b != 8'd11) err = ERR_APP_SIZE;
					end else if (off_q > 4'd11 || b != app_byte(off_q - 4'd1))
						err = (off_q <= 4'd8) ? ERR_APP_ID : ERR_APP_AUTH;
					if (err == ERR_NONE && off_q >= 4'd11) begin
						phase_d = P_APP_TAIL; off_d = '0;
					end else off_d = off_q + 4'd1;
				end
				P_APP_TAIL: begin
					case (off_q)
						4'd0: if (b != 8'd3) err = ERR_LOOP_SIZE;
						4'd1: if (b != 8'd1) err = ERR_LOOP_ID;
						4'd2: gw_d[0] = {8'h00, b};
						4'd3: gw_d[0] = {b, gw_q[0][7:0]};
						default: begin
							if (b != 8'd0) err = ERR_LOOP_TERM;
							else begin
								rec = 1'b1;
								r.event_kind = EV_LOOP; r.word_a = gw_q[0]; phase_d = P_BLOCK;
							end
						end
					endcase
					off_d = off_q + 4'd1;
				end
				P_SKIP_LEN: begin
					if (b == 8'd0) phase_d = P_BLOCK;
					else begin
						skip_d = {2'b00, b}; phase_d = P_SKIP_DATA;
					end
				end
				P_IMG: begin
					if (off_q < 4'd8) begin
						if (off_q[0]) gw_d[off_q[2:1]] = {b, gw_q[off_q[2:1]][7:0]};
						else gw_d[off_q[2:1]] = {8'h00, b};
						if (off_q == 4'd7) begin
							// height word completes in this byte
							sh = {1'b0, b, gw_q[3][7:0]} + {1'b0, gw_q[1]};
							if (sw[16] || sh[16] || gw_q[2] == '0 ||
									{b, gw_q[3][7:0]} == '0)
								err = ERR_FR_SIZE;
							else if (sw[15:0] > cw_q || sh[15:0] > ch_q)
								err = ERR_FR_BOUNDS;
						end
						off_d = off_q + 4'd1;
					end else begin
						gf0_d = b; rec = 1'b1;
						r.event_kind = EV_FRAME; r.word_a = gw_q[0]; r.word_b = gw_q[1];
						r.word_c = gw_q[2]; r.word_d = gw_q[3]; r.packed_flags = b;
						r.frame_number = fn16;
						if (b[7]) begin
							skip_d = table_bytes(b); phase_d = P_LCT;
						end else phase_d = P_MIN;
						off_d = '0;
					end
				end
				P_MIN: begin
					gf1_d = b; sum_d = '0; phase_d = P_DLEN;
				end
				P_DLEN: begin
					if (b == 8'd0) begin
						if (sum_q == '0) err = ERR_FR_EMPTY;
						else begin
							rec = 1'b1;
							r.event_kind = EV_DATA; r.byte_one = gf1_q; r.frame_number = fn16;
							r.byte_count = 24'(sum_q);
							if (fc_q != FCAP) fc_d = fc_q + 1'b1;
							gce_d = 1'b0; phase_d = P_BLOCK;
						end
					end else begin
						sum_d = sum_add[COUNT_BITS] ? CCAP : sum_add[COUNT_BITS-1:0];
						skip_d = {2'b00, b}; phase_d = P_DSKIP;
					end
				end
				P_TAIL: if (sum_q != CCAP) sum_d = sum_q + 1'b1;
				default: ;
			endcase
			if (err != ERR_NONE) begin
				tail.event_kind = EV_ERROR; tail.error_code = err; halt_d = 1'b1;
			end else if (in_word.is_last) begin
				if (phase_d == P_TAIL) begin
					tail.event_kind = EV_FINISH; tail.byte_count = 24'(sum_d);
				end else begin
					tail.event_kind = EV_ERROR; tail.error_code = ERR_TRUNC;
				end
			end
			tail.last_of_run = 1'b1;
			if (err != ERR_NONE || in_word.is_last) begin
				if (rec) begin
					res0 = r; res1 = tail; res_n = 2'd2;
				end else begin
					res0 = tail; res1 = tail; res_n = 2'd1;
				end
			end else begin
				r.last_of_run = 1'b1;
				res0 = r; res1 = tail; res_n = rec ? 2'd1 : 2'd0;
			end
		end else begin
			res0 = r; res1 = tail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_SIG; off_q <= '0; skip_q <= '0; sum_q <= '0;
			cw_q <= '0; ch_q <= '0; gw_q <= '{default: '0}; gf0_q <= '0; gf1_q <= '0;
			fc_q <= '0; gce_q <= 1'b0; halt_q <= 1'b0;
		end else if (step) begin
			if (in_word.is_last) begin
				phase_q <= P_SIG; off_q <= '0; skip_q <= '0; sum_q <= '0;
				cw_q <= '0; ch_q <= '0; gw_q <= '{default: '0}; gf0_q <= '0;
				gf1_q <= '0; fc_q <= '0; gce_q <= 1'b0; halt_q <= 1'b0;
			end else begin
				phase_q <= phase_d; off_q <= off_d; skip_q <= skip_d; sum_q <= sum_d;
				cw_q <= cw_d; ch_q <= ch_d; gw_q <= gw_d; gf0_q <= gf0_d;
				gf1_q <= gf1_d; fc_q <= fc_d; gce_q <= gce_d; halt_q <= halt_d;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/gcp_outq.sv
// ---------------------------------------------------------------------------
// gcp_outq
// Four-entry result queue; takes up to two words per cycle, emits one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gcp_outq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         push_n,
	input  wire gcp_pkg::out_word_t push0,
	input  wire gcp_pkg::out_word_t push1,
	output logic                    room,
	output logic                    valid,
	input  wire logic               ready,
	output gcp_pkg::out_word_t      head
);
	import gcp_pkg::*;

	out_word_t  mem_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign valid = (cnt_q != 3'd0);
	assign head = mem_q[rd_q];
	assign pop = valid && ready;
	// two free slots needed for a worst-case byte
	assign room = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_q] <= push0;
		if (push_n == 2'd2) mem_q[wr_q + 2'd1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr_q + push_n;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end
endmodule
`default_nettype wire

FILE: hdl/gcp_checker.sv
// ---------------------------------------------------------------------------
// gcp_checker
// Port-level checks for the container parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gif89a_container_parser_macros.svh"
module gcp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire gcp_pkg::in_word_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire gcp_pkg::out_word_t out_data
);
	import gcp_pkg::*;

	`GCP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed under stall")
	`GCP_ASSERT_IMP(a_err_code, clk, arst_n, out_valid && out_data.event_kind == EV_ERROR, out_data.error_code != ERR_NONE && out_data.last_of_run, "error word malformed")
	`GCP_ASSERT_IMP(a_noerr_code, clk, arst_n, out_valid && out_data.event_kind != EV_ERROR, out_data.error_code == ERR_NONE, "code on non-error word")
	`GCP_ASSERT_IMP(a_finish_last, clk, arst_n, out_valid && out_data.event_kind == EV_FINISH, out_data.last_of_run, "finish not last")
	`GCP_ASSERT_NEXT(a_no_out_idle, clk, arst_n, !out_valid && !(in_valid && in_ready), !out_valid, "word from nowhere")
endmodule

bind gif89a_container_parser gcp_checker u_chk (.*);
`default_nettype wire

FILE: dv/gif89a_container_parser_tb.sv
// ---------------------------------------------------------------------------
// gif89a_container_parser_tb
// Streams generated GIF files through the parser one byte per word, predicts
// every record from a behavioral model of the parse state and compares each
// record field by field, under random idling and long receiver stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gif89a_container_parser_tb;
	import gcp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	typedef enum logic [3:0] {
		PH_SIG, PH_SCREEN, PH_GCT, PH_BLOCK, PH_EXT_TYPE, PH_GCE, PH_APP_HEAD,
		PH_APP_TAIL, PH_SKIP_LEN, PH_SKIP_DATA, PH_IMG, PH_LCT, PH_MIN, PH_DLEN,
		PH_DSKIP, PH_TAIL
	} parse_phase_t;

	localparam logic [7:0] SIG_TXT [6] = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61};
	localparam logic [7:0] LOOP_APP_ID [11] = '{8'h4E, 8'h45, 8'h54, 8'h53, 8'h43,
		8'h41, 8'h50, 8'h45, 8'h32, 8'h2E, 8'h30};
	localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;

	gif89a_container_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// parse state mirrored by the predictor
	parse_phase_t ph;
	logic [3:0] f_off;
	logic [9:0] skip_left;
	logic [23:0] len_sum;
	logic [15:0] canvas_w, canvas_h;
	logic [15:0] g_words [4];
	logic [7:0] g_flags [2];
	logic [15:0] frames_seen;
	logic gce_pending;
	logic stopped;

	out_word_t expected_records [$];
	logic [7:0] file_bytes [$];

	int mismatches = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;

	function automatic void clear_parse();
		ph = PH_SIG;
		f_off = '0;
		skip_left = '0;
		len_sum = '0;
		canvas_w = '0;
		canvas_h = '0;
		for (int i = 0; i < 4; i++) g_words[i] = '0;
		g_flags[0] = '0;
		g_flags[1] = '0;
		frames_seen = '0;
		gce_pending = 1'b0;
		stopped = 1'b0;
	endfunction

	function automatic out_word_t blank_record(input logic [2:0] kind, input logic [4:0] code);
		out_word_t r;
		r = '0;
		r.event_kind = kind;
		r.error_code = code;
		return r;
	endfunction

	function automatic logic [9:0] color_table_len(input logic [7:0] flags);
		return 10'(10'd3 << (int'(flags[2:0]) + 1));
	endfunction

	// advance the parse by one byte and queue the records it causes
	function automatic void predict_records(input logic [7:0] b, input logic last);
		logic [4:0] err;
		logic [3:0] off;
		int n0;
		out_word_t r;
		logic [16:0] sum_x, sum_y;
		logic [24:0] wide_sum;
		int i;
		err = ERR_NONE;
		off = f_off;
		n0 = expected_records.size();
		if (stopped) begin
			if (last) clear_parse();
			return;
		end
		case (ph)
			PH_SIG: begin
				if (off > 5 || b != SIG_TXT[off]) err = (off < 3) ? ERR_SIG : ERR_VER;
				else if (off == 5) begin
					ph = PH_SCREEN;
					off = 0;
				end else off++;
			end
			PH_SCREEN: begin
				case (off)
					0: canvas_w = {8'h00, b};
					1: canvas_w[15:8] = b;
					2: canvas_h = {8'h00, b};
					3: canvas_h[15:8] = b;
					4: g_flags[0] = b;
					5: g_flags[1] = b;
					default: begin
						r = blank_record(EV_SCREEN, ERR_NONE);
						r.word_a = canvas_w;
						r.word_b = canvas_h;
						r.packed_flags = g_flags[0];
						r.byte_one = g_flags[1];
						r.byte_two = b;
						expected_records.push_back(r);
						if (g_flags[0][7]) begin
							skip_left = color_table_len(g_flags[0]);
							ph = PH_GCT;
						end else ph = PH_BLOCK;
					end
				endcase
				off++;
			end
			PH_GCT, PH_LCT: begin
				if (skip_left > 0) skip_left--;
				if (skip_left == 0) ph = (ph == PH_GCT) ? PH_BLOCK : PH_MIN;
			end
			PH_BLOCK: begin
				off = 0;
				if (b == B_EXT) ph = PH_EXT_TYPE;
				else if (b == B_IMG) ph = PH_IMG;
				else if (b == B_TRAILER) begin
					if (frames_seen == 0) err = ERR_NO_FRAME;
					else begin
						ph = PH_TAIL;
						len_sum = '0;
					end
				end else err = ERR_BLOCK;
			end
			PH_EXT_TYPE: begin
				off = 0;
				if (b == X_GCE) begin
					if (gce_pending) err = ERR_GCE_TWICE;
					else begin
						gce_pending = 1'b1;
						ph = PH_GCE;
					end
				end else if (b == X_APP) ph = PH_APP_HEAD;
				else if (b == X_COMMENT || b == X_TEXT) ph = PH_SKIP_LEN;
				else err = ERR_EXT;
			end
			PH_GCE: begin
				case (off)
					0: if (b != 8'd4) err = ERR_GCE_SIZE;
					1: g_flags[0] = b;
					2: g_words[0] = {8'h00, b};
					3: g_words[0][15:8] = b;
					4: g_flags[1] = b;
					default: begin
						if (b != 8'd0) err = ERR_GCE_TERM;
						else if (g_flags[0][4:2] > 3) err = ERR_DISPOSAL;
						else begin
							r = blank_record(EV_GCE, ERR_NONE);
							r.word_a = g_words[0];
							r.packed_flags = g_flags[0];
							r.byte_one = g_flags[1];
							r.frame_number = frames_seen;
							expected_records.push_back(r);
							ph = PH_BLOCK;
						end
					end
				endcase
				off++;
			end
			PH_APP_HEAD: begin
				if (off == 0) begin
					if (b != 8'd11) err = ERR_APP_SIZE;
				end else if (off > 11) err = (off <= 8) ? ERR_APP_ID : ERR_APP_AUTH;
				else if (b != LOOP_APP_ID[off - 1]) err = (off <= 8) ? ERR_APP_ID : ERR_APP_AUTH;
				if (err == ERR_NONE && off >= 11) begin
					ph = PH_APP_TAIL;
					off = 0;
				end else off++;
			end
			PH_APP_TAIL: begin
				case (off)
					0: if (b != 8'd3) err = ERR_LOOP_SIZE;
					1: if (b != 8'd1) err = ERR_LOOP_ID;
					2: g_words[0] = {8'h00, b};
					3: g_words[0][15:8] = b;
					default: begin
						if (b != 8'd0) err = ERR_LOOP_TERM;
						else begin
							r = blank_record(EV_LOOP, ERR_NONE);
							r.word_a = g_words[0];
							expected_records.push_back(r);
							ph = PH_BLOCK;
						end
					end
				endcase
				off++;
			end
			PH_SKIP_LEN: begin
				if (b == 0) ph = PH_BLOCK;
				else begin
					skip_left = {2'b00, b};
					ph = PH_SKIP_DATA;
				end
			end
			PH_SKIP_DATA, PH_DSKIP: begin
				if (skip_left > 0) skip_left--;
				if (skip_left == 0) ph = (ph == PH_SKIP_DATA) ? PH_SKIP_LEN : PH_DLEN;
			end
			PH_IMG: begin
				if (off < 8) begin
					i = off[2:1];
					if (off[0]) g_words[i][15:8] = b;
					else g_words[i] = {8'h00, b};
					if (off == 7) begin
						sum_x = {1'b0, g_words[2]} + {1'b0, g_words[0]};
						sum_y = {1'b0, g_words[3]} + {1'b0, g_words[1]};
						if (sum_x > 17'hFFFF || sum_y > 17'hFFFF || g_words[2] == 0
								|| g_words[3] == 0) err = ERR_FR_SIZE;
						else if (sum_x > {1'b0, canvas_w} || sum_y > {1'b0, canvas_h})
							err = ERR_FR_BOUNDS;
					end
					off++;
				end else begin
					g_flags[0] = b;
					r = blank_record(EV_FRAME, ERR_NONE);
					r.word_a = g_words[0];
					r.word_b = g_words[1];
					r.word_c = g_words[2];
					r.word_d = g_words[3];
					r.packed_flags = b;
					r.frame_number = frames_seen;
					expected_records.push_back(r);
					if (b[7]) begin
						skip_left = color_table_len(b);
						ph = PH_LCT;
					end else ph = PH_MIN;
					off = 0;
				end
			end
			PH_MIN: begin
				g_flags[1] = b;
				len_sum = '0;
				ph = PH_DLEN;
			end
			PH_DLEN: begin
				if (b == 0) begin
					if (len_sum == 0) err = ERR_FR_EMPTY;
					else begin
						r = blank_record(EV_DATA, ERR_NONE);
						r.byte_one = g_flags[1];
						r.frame_number = frames_seen;
						r.byte_count = len_sum;
						expected_records.push_back(r);
						if (frames_seen != 16'hFFFF) frames_seen++;
						gce_pending = 1'b0;
						ph = PH_BLOCK;
					end
				end else begin
					wide_sum = {1'b0, len_sum} + 25'(b);
					len_sum = wide_sum[24] ? COUNT_MAX : wide_sum[23:0];
					skip_left = {2'b00, b};
					ph = PH_DSKIP;
				end
			end
			PH_TAIL: if (len_sum != COUNT_MAX) len_sum++;
			default: ;
		endcase
		f_off = off;
		if (err != ERR_NONE) begin
			expected_records.push_back(blank_record(EV_ERROR, err));
			stopped = 1'b1;
		end
		if (last) begin
			if (err == ERR_NONE) begin
				if (ph == PH_TAIL) begin
					r = blank_record(EV_FINISH, ERR_NONE);
					r.byte_count = len_sum;
					expected_records.push_back(r);
				end else expected_records.push_back(blank_record(EV_ERROR, ERR_TRUNC));
			end
			clear_parse();
		end
		if (expected_records.size() > n0)
			expected_records[expected_records.size() - 1].last_of_run = 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] record %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// record checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_records.size() == 0) begin
				report_mismatch("with none pending", int'(out_data.event_kind), 0);
			end else begin
				want = expected_records.pop_front();
				if (out_data.event_kind !== want.event_kind)
					report_mismatch("event_kind", out_data.event_kind, want.event_kind);
				if (out_data.error_code !== want.error_code)
					report_mismatch("error_code", out_data.error_code, want.error_code);
				if (out_data.word_a !== want.word_a)
					report_mismatch("word_a", out_data.word_a, want.word_a);
				if (out_data.word_b !== want.word_b)
					report_mismatch("word_b", out_data.word_b, want.word_b);
				if (out_data.word_c !== want.word_c)
					report_mismatch("word_c", out_data.word_c, want.word_c);
				if (out_data.word_d !== want.word_d)
					report_mismatch("word_d", out_data.word_d, want.word_d);
				if (out_data.packed_flags !== want.packed_flags)
					report_mismatch("packed_flags", out_data.packed_flags, want.packed_flags);
				if (out_data.byte_one !== want.byte_one)
					report_mismatch("byte_one", out_data.byte_one, want.byte_one);
				if (out_data.byte_two !== want.byte_two)
					report_mismatch("byte_two", out_data.byte_two, want.byte_two);
				if (out_data.frame_number !== want.frame_number)
					report_mismatch("frame_number", out_data.frame_number, want.frame_number);
				if (out_data.byte_count !== want.byte_count)
					report_mismatch("byte_count", out_data.byte_count, want.byte_count);
				if (out_data.last_of_run !== want.last_of_run)
					report_mismatch("last_of_run", out_data.last_of_run, want.last_of_run);
			end
		end
	end

	// receiver side: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one byte word; returns right after the edge that accepts it
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, is_last: last};
		do @(posedge clk); while (!in_ready);
		predict_records(b, last);
	endtask

	task automatic send_file();
		foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		wait (expected_records.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void add_word(input logic [15:0] w);
		file_bytes.push_back(w[7:0]);
		file_bytes.push_back(w[15:8]);
	endfunction

	function automatic void add_random_bytes(input int n);
		repeat (n) file_bytes.push_back(8'($urandom));
	endfunction

	function automatic void add_sub_blocks(input int nblk, input int maxlen);
		int len;
		repeat (nblk) begin
			len = $urandom_range(maxlen, 1);
			file_bytes.push_back(8'(len));
			add_random_bytes(len);
		end
		file_bytes.push_back(8'h00);
	endfunction

	// a well-formed file with random content; big tables only now and then
	function automatic void build_good_file(input int max_frames);
		logic [15:0] cw, ch, l, t, w, h;
		logic [7:0] flags;
		flags = 8'($urandom);
		flags[2:0] = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(2));
		cw = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(400, 1));
		ch = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(400, 1));
		file_bytes.delete();
		foreach (SIG_TXT[i]) file_bytes.push_back(SIG_TXT[i]);
		add_word(cw);
		add_word(ch);
		file_bytes.push_back(flags);
		add_random_bytes(2);
		if (flags[7]) add_random_bytes(int'(color_table_len(flags)));
		repeat ($urandom_range(max_frames, 1)) begin
			if ($urandom_range(3) == 0) begin
				file_bytes.push_back(B_EXT);
				file_bytes.push_back(X_APP);
				file_bytes.push_back(8'd11);
				foreach (LOOP_APP_ID[i]) file_bytes.push_back(LOOP_APP_ID[i]);
				file_bytes.push_back(8'd3);
				file_bytes.push_back(8'd1);
				add_word(16'($urandom));
				file_bytes.push_back(8'h00);
			end
			if ($urandom_range(3) == 0) begin
				file_bytes.push_back(B_EXT);
				file_bytes.push_back($urandom_range(1) ? X_COMMENT : X_TEXT);
				add_sub_blocks($urandom_range(2), 12);
			end
			if ($urandom_range(1)) begin
				file_bytes.push_back(B_EXT);
				file_bytes.push_back(X_GCE);
				file_bytes.push_back(8'd4);
				flags = 8'($urandom);
				flags[4:2] = 3'($urandom_range(3));
				file_bytes.push_back(flags);
				add_word(16'($urandom));
				file_bytes.push_back(8'($urandom));
				file_bytes.push_back(8'h00);
			end
			l = 16'($urandom_range(int'(cw) - 1));
			t = 16'($urandom_range(int'(ch) - 1));
			w = 16'($urandom_range(int'(cw - l), 1));
			h = 16'($urandom_range(int'(ch - t), 1));
			file_bytes.push_back(B_IMG);
			add_word(l);
			add_word(t);
			add_word(w);
			add_word(h);
			flags = 8'($urandom);
			flags[2:0] = 3'($urandom_range(1));
			file_bytes.push_back(flags);
			if (flags[7]) add_random_bytes(int'(color_table_len(flags)));
			file_bytes.push_back(8'($urandom_range(8, 2)));
			add_sub_blocks($urandom_range(3, 1), 24);
		end
		file_bytes.push_back(B_TRAILER);
		add_random_bytes($urandom_range(4));
	endfunction

	task automatic test_directed();
		// minimal file: no tables, one frame, nothing after the trailer
		file_bytes = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h01, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h00, 8'h00, B_IMG, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h01, 8'h00, 8'h00, 8'h02, 8'h01, 8'hFF, 8'h00, B_TRAILER};
		send_file();
		// bad first byte with the end flag on the same byte
		file_bytes = '{8'h00};
		send_file();
		// bad version byte, then ignored bytes up to end of file
		file_bytes = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'hFF, 8'h00};
		send_file();
		// trailer before any frame
		file_bytes = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'h00, 8'hFF, 8'hFF, B_TRAILER};
		send_file();
		// truncated right after the signature
		file_bytes = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61};
		send_file();
		wait_drained();
	endtask

	// mostly good files, some with one corrupted byte, cut short, or pure noise
	task automatic test_random_files(input int byte_budget);
		int sent;
		int pick;
		sent = 0;
		while (sent < byte_budget) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				file_bytes.delete();
				add_random_bytes($urandom_range(12, 1));
				if ($urandom_range(1)) file_bytes[0] = SIG_TXT[0];
			end else begin
				build_good_file(4);
				if (pick < 40)
					file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
				else if (pick < 55)
					file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
			end
			sent += file_bytes.size();
			send_file();
		end
	endtask

	task automatic test_receiver_stall();
		rx_hold = 300;
		build_good_file(6);
		send_file();
		wait_drained();
	endtask

	task automatic test_sender_pause();
		build_good_file(2);
		send_file();
		wait_drained();
		build_good_file(2);
		send_file();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		clear_parse();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 11;
		rx_idle_pct = 72;
		test_directed();
		test_random_files(200);
		test_receiver_stall();
		wait_drained();

		tx_idle_pct = 72;
		rx_idle_pct = 11;
		test_random_files(200);
		test_sender_pause();
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_files(200);
		test_receiver_stall();

		wait_drained();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire
